FILE: rtl/efsq_pkg.sv
// Package for the earliest-free server queue.
// Holds the field widths, register indexes, reset values and the commit record type.
// No dependencies; every other file of the block but efsq_ram imports it.
`default_nettype none

package efsq_pkg;

    // Field widths of the transfer payloads and of the stored state.
    localparam int ARRIVE_W  = 17;
    localparam int SERVICE_W = 10;
    localparam int SERVER_W  = 7;
    localparam int FREE_W    = 32;
    localparam int WAIT_W    = 32;
    localparam int TOTAL_W   = 48;
    localparam int COUNT_W   = 32;
    localparam int SVC_SEC_W = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int WINDOWS_W  = 8;
    localparam int TIME_W     = 17;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_WINDOWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_TIME   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TIME  = 2'd2;

    // Register values after reset: one window, open 08:00:00, close 17:00:00.
    localparam logic [WINDOWS_W-1:0] NUM_WINDOWS_RST = 8'd1;
    localparam logic [TIME_W-1:0]    OPEN_TIME_RST   = 17'd28800;
    localparam logic [TIME_W-1:0]    CLOSE_TIME_RST  = 17'd61200;

    localparam logic [6:0] SEC_PER_MIN = 7'd60;

    // One finished customer handed from the scheduler to the accounting unit.
    typedef struct packed {
        logic                 fire;
        logic                 late;
        logic [ARRIVE_W-1:0]  arrive;
        logic [SERVICE_W-1:0] service;
        logic [FREE_W-1:0]    free_at;
        logic [SERVER_W-1:0]  server;
    } efsq_commit_t;

endpackage

`default_nettype wire

FILE: rtl/efsq_if.sv
// Valid/ready channel interfaces for customer items and result items.
// Depends on efsq_pkg for the field widths.
`default_nettype none

interface efsq_in_if;
    import efsq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ARRIVE_W-1:0]  arrive_second;
    logic [SERVICE_W-1:0] service_minutes;

    modport source (output valid, output arrive_second, output service_minutes, input ready);
    modport sink   (input valid, input arrive_second, input service_minutes, output ready);
endinterface

interface efsq_out_if;
    import efsq_pkg::*;

    logic                valid;
    logic                ready;
    logic                accepted;
    logic [SERVER_W-1:0] server_index;
    logic [WAIT_W-1:0]   wait_seconds;
    logic [TOTAL_W-1:0]  total_wait_seconds;
    logic [COUNT_W-1:0]  served_count;

    modport source (output valid, output accepted, output server_index, output wait_seconds,
                    output total_wait_seconds, output served_count, input ready);
    modport sink   (input valid, input accepted, input server_index, input wait_seconds,
                    input total_wait_seconds, input served_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/efsq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module efsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/efsq_sched.sv
// Scheduler: configuration registers, free-time clearing sweep and the minimum scan.
// Depends on efsq_pkg, efsq_if and drives the ports of one efsq_ram.
`default_nettype none

module efsq_sched #(
    parameter int MAX_SERVERS = 128
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [efsq_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [efsq_pkg::CFG_DATA_W-1:0]        cfg_data,
    efsq_in_if.sink                                     in_ch,
    output logic                                        ram_we,
    output logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] ram_waddr,
    output logic [efsq_pkg::FREE_W-1:0]                 ram_wdata,
    output logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] ram_raddr,
    input  wire logic [efsq_pkg::FREE_W-1:0]            ram_rdata,
    input  wire logic                                   out_free,
    input  wire logic [efsq_pkg::FREE_W-1:0]            next_free,
    output efsq_pkg::efsq_commit_t                      commit
);
    import efsq_pkg::*;

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [WINDOWS_W-1:0] num_windows_reg;
    logic [TIME_W-1:0]    open_time_reg;
    logic [TIME_W-1:0]    close_time_reg;

    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [IDX_W-1:0]     last_reg, last_next;
    logic [IDX_W-1:0]     best_reg, best_next;
    logic [FREE_W-1:0]    best_val_reg, best_val_next;
    logic [ARRIVE_W-1:0]  arrive_reg, arrive_next;
    logic [SERVICE_W-1:0] service_reg, service_next;
    logic                 late_reg, late_next;

    logic                 in_xfer;
    logic                 open_wr;
    logic [IDX_W-1:0]     n_last;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign open_wr     = cfg_wr_en && (cfg_index == REG_OPEN_TIME);

    // Index of the last server in use, with zero treated as one and an
    // oversized count clamped to the built server count.
    always_comb
    begin
        if (num_windows_reg == '0)
        begin
            n_last = '0;
        end
        else if (32'(num_windows_reg) > MAX_SERVERS)
        begin
            n_last = IDX_W'(MAX_SERVERS - 1);
        end
        else
        begin
            n_last = IDX_W'(32'(num_windows_reg) - 32'd1);
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_windows_reg <= NUM_WINDOWS_RST;
            open_time_reg   <= OPEN_TIME_RST;
            close_time_reg  <= CLOSE_TIME_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_NUM_WINDOWS: num_windows_reg <= cfg_data[WINDOWS_W-1:0];
                REG_OPEN_TIME:   open_time_reg   <= cfg_data[TIME_W-1:0];
                REG_CLOSE_TIME:  close_time_reg  <= cfg_data[TIME_W-1:0];
                default:         ;
            endcase
        end
    end

    // Memory ports. The clearing sweep writes the opening time to every
    // entry; a commit writes the chosen server's new free time. The next scan
    // starts only after the commit, so no read ever overlaps a pending write.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = FREE_W'(open_time_reg);
        ram_raddr = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_SCAN:
            begin
                ram_raddr = ptr_reg + IDX_W'(1);
            end
            S_COMMIT:
            begin
                ram_we    = out_free && !late_reg;
                ram_waddr = best_reg;
                ram_wdata = next_free;
            end
            default: ;
        endcase
    end

    // Sequencer: sweep, wait for a customer, scan for the earliest free server
    // unless the customer arrives after close time, then commit once the result slot can take it.
    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        last_next     = last_reg;
        best_next     = best_reg;
        best_val_next = best_val_reg;
        arrive_next   = arrive_reg;
        service_next  = service_reg;
        late_next     = late_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (ptr_reg == IDX_W'(MAX_SERVERS - 1))
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    arrive_next  = in_ch.arrive_second;
                    service_next = in_ch.service_minutes;
                    late_next    = (in_ch.arrive_second > close_time_reg);
                    last_next    = n_last;
                    ptr_next     = '0;
                    state_next   = (in_ch.arrive_second > close_time_reg) ? S_COMMIT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Strict less-than keeps the lowest index on ties.
                if ((ptr_reg == '0) || (ram_rdata < best_val_reg))
                begin
                    best_next     = ptr_reg;
                    best_val_next = ram_rdata;
                end
                if (ptr_reg == last_reg)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                ptr_next   = '0;
            end
        endcase

        // A new opening time reloads every server.
        if (open_wr)
        begin
            state_next = S_CLEAR;
            ptr_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ptr_reg   <= '0;
            late_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            late_reg  <= late_next;
        end
    end

    // Item payload and scan result.
    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        best_reg     <= best_next;
        best_val_reg <= best_val_next;
        arrive_reg   <= arrive_next;
        service_reg  <= service_next;
    end

    always_comb
    begin
        commit.fire    = (state_reg == S_COMMIT) && out_free;
        commit.late    = late_reg;
        commit.arrive  = arrive_reg;
        commit.service = service_reg;
        commit.free_at = best_val_reg;
        commit.server  = SERVER_W'(best_reg);
    end

endmodule

`default_nettype wire

FILE: rtl/efsq_acct.sv
// Accounting unit: wait and new free time of a customer, running totals, result register.
// Depends on efsq_pkg and efsq_if.
`default_nettype none

module efsq_acct (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire efsq_pkg::efsq_commit_t        commit,
    output logic                               out_free,
    output logic [efsq_pkg::FREE_W-1:0]        next_free,
    efsq_out_if.source                         out_ch
);
    import efsq_pkg::*;

    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 valid_reg;
    logic                 accepted_reg;
    logic [SERVER_W-1:0]  server_reg;
    logic [WAIT_W-1:0]    wait_reg;

    logic                 early;
    logic [FREE_W-1:0]    start;
    logic [WAIT_W-1:0]    wait_sec;
    logic [SVC_SEC_W-1:0] svc_sec;
    logic [FREE_W:0]      free_sum;
    logic [TOTAL_W:0]     total_sum;

    assign out_free = !valid_reg || out_ch.ready;

    // Service starts at the later of arrival and the server's free time.
    always_comb
    begin
        early     = FREE_W'(commit.arrive) < commit.free_at;
        start     = early ? commit.free_at : FREE_W'(commit.arrive);
        wait_sec  = early ? (commit.free_at - FREE_W'(commit.arrive)) : '0;
        svc_sec   = SVC_SEC_W'(commit.service) * SVC_SEC_W'(SEC_PER_MIN);
        free_sum  = {1'b0, start} + (FREE_W + 1)'(svc_sec);
        next_free = free_sum[FREE_W] ? '1 : free_sum[FREE_W-1:0];
    end

    // Saturating totals.
    always_comb
    begin
        total_sum  = {1'b0, total_reg} + (TOTAL_W + 1)'(wait_sec);
        total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
        count_next = (count_reg == '1) ? count_reg : count_reg + COUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (commit.fire && !commit.late)
            begin
                total_reg <= total_next;
                count_reg <= count_next;
            end
            if (commit.fire)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result register; a late customer reports zeros and the unchanged totals.
    always_ff @(posedge clk)
    begin
        if (commit.fire)
        begin
            accepted_reg <= !commit.late;
            server_reg   <= commit.late ? '0 : commit.server;
            wait_reg     <= commit.late ? '0 : wait_sec;
        end
    end

    assign out_ch.valid              = valid_reg;
    assign out_ch.accepted           = accepted_reg;
    assign out_ch.server_index       = server_reg;
    assign out_ch.wait_seconds       = wait_reg;
    assign out_ch.total_wait_seconds = total_reg;
    assign out_ch.served_count       = count_reg;

endmodule

`default_nettype wire

FILE: rtl/earliest_free_server_queue.sv
// Earliest-free server queue. Each customer transfer arriving by close_time
// is sent to the server that becomes free first (lowest index on ties), and
// one result transfer reports its wait, server and the running totals.
// Server free times live in a RAM of MAX_SERVERS words read one entry per
// cycle while the servers in use are scanned; a customer who arrives after
// close_time skips the scan. The result register lets the next customer be
// accepted while a result waits. After reset, and after every write of
// open_time, a clearing pass loads the opening time into every server; no
// customer is accepted during it.
// Depends on efsq_pkg, efsq_if, efsq_ram, efsq_sched and efsq_acct.
`default_nettype none

module earliest_free_server_queue #(
    parameter int MAX_SERVERS = 128
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [efsq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [efsq_pkg::CFG_DATA_W-1:0] cfg_data,
    efsq_in_if.sink                              in_ch,
    efsq_out_if.source                           out_ch
);
    import efsq_pkg::*;

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [FREE_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [FREE_W-1:0] ram_rdata;
    logic              out_free;
    logic [FREE_W-1:0] next_free;
    efsq_commit_t      commit;

    // Server free-time store.
    efsq_ram #(
        .WIDTH (FREE_W),
        .DEPTH (MAX_SERVERS)
    ) u_free_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration, clearing sweep and minimum scan.
    efsq_sched #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_free  (out_free),
        .next_free (next_free),
        .commit    (commit)
    );

    // Wait, free-time update, totals and result register.
    efsq_acct u_acct (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (commit),
        .out_free  (out_free),
        .next_free (next_free),
        .out_ch    (out_ch)
    );

    // A commit never overwrites a result that has not been transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit.fire |-> !(out_ch.valid && !out_ch.ready))
        else $error("commit overwrote a pending result");

    // Every commit shows up as a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit.fire |=> out_ch.valid)
        else $error("commit did not produce a result");

    // Free-time writes stay inside the built server count.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (32'(ram_waddr) < MAX_SERVERS))
        else $error("free-time write out of range");

    // A rejected customer reports no server and no wait.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.accepted) |->
            ((out_ch.server_index == '0) && (out_ch.wait_seconds == '0)))
        else $error("rejected customer reports a server or a wait");

endmodule

`default_nettype wire
